FILE: rtl/byte_histogram_compactor_macros.svh
// assertion macros used by the histogram top level
// expects i_clk and i_rst_n in the scope of each use
`ifndef BYTE_HISTOGRAM_COMPACTOR_MACROS_SVH
`define BYTE_HISTOGRAM_COMPACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define BHC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bhc assertion failed");
`define BHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bhc assertion failed");
`define BHC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("bhc assertion failed");
`else
`define BHC_ASSERT_IMPL(label, ante, cons)
`define BHC_ASSERT_NEXT(label, ante, cons)
`define BHC_ASSERT_ALWAYS(label, cond)
`endif
`endif

FILE: rtl/bhc_pkg.sv
// shared constants and types of the byte histogram
// no dependencies
package bhc_pkg;

    localparam int SYMBOLS    = 256;
    localparam int COUNT_BITS = 32;
    localparam int ADDR_W     = $clog2(SYMBOLS);
    localparam int PTR_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int OCC_W      = 32;
    localparam int POS_W      = 9;

    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [PTR_W-1:0]      SCAN_END  = PTR_W'(SYMBOLS);

    // one access cycle of the bin store
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [COUNT_BITS-1:0] wr_data;
        logic                  clr;
    } t_store_req;

endpackage

FILE: rtl/bhc_bin_store.sv
// bin counter memory with per-bin valid flags, one read and one write port
// depends on bhc_pkg
module bhc_bin_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bhc_pkg::t_store_req            i_req,
    output logic [bhc_pkg::COUNT_BITS-1:0] o_rd_data
);
    import bhc_pkg::*;

    logic [COUNT_BITS-1:0] r_mem [SYMBOLS];
    logic [SYMBOLS-1:0]    r_vld;
    logic [COUNT_BITS-1:0] r_rdata;
    logic                  r_rvld;

    // memory array, registered read before write
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    // valid flags: a bin not written since clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rvld <= r_vld[i_req.rd_addr];
            end
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

FILE: rtl/byte_histogram_compactor.sv
// top level of the byte histogram with compacted read-out
// depends on bhc_pkg, bhc_bin_store and byte_histogram_compactor_macros.svh
//
// Counts byte values into 256 saturating 32-bit bins held in one simple dual-port
// memory (one read, one write per cycle, registered read data).
// Count requests are taken every cycle while no read walk runs: the read of a
// bin is issued when the request is taken and the incremented value is written
// back the next cycle, with a bypass of the last written value for a repeat of
// the same byte. A read request walks the bins upward from the scan pointer,
// each bin examined by a memory read (ST_ISSUE), then a test (ST_CHECK);
// input is held off while a walk is running.
// A result waits in an output register; counts and clears keep flowing while
// it waits. Clear requests drop the per-bin valid flags at once, so there is
// no clearing pass after reset or clear.
`include "byte_histogram_compactor_macros.svh"
module byte_histogram_compactor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [0] found, [8:1] symbol, [40:9] occurrences,
                                        // [49:41] list_position, [55:50] zero
);
    import bhc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_CHECK = 3'b100
    } t_state;

    t_state r_state, n_state;

    // request decode
    logic              in_acc;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] byte_value;
    logic              cnt_acc, rd_acc, clr_acc;
    logic              byte_in_range;

    assign cmd           = s_axis_tuser[CMD_W-1:0];
    assign byte_value    = s_axis_tdata[BYTE_W-1:0];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cnt_acc       = in_acc && (cmd == CMD_COUNT);
    assign rd_acc        = in_acc && (cmd == CMD_READ);
    assign clr_acc       = in_acc && (cmd == CMD_CLEAR);
    assign byte_in_range = ({1'b0, byte_value} < SCAN_END);

    // count write-back stage and bypass of the last write
    logic                  r_s1_vld;
    logic [ADDR_W-1:0]     r_s1_addr;
    logic                  r_wb_vld;
    logic [ADDR_W-1:0]     r_wb_addr;
    logic [COUNT_BITS-1:0] r_wb_data;
    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] s1_old;
    logic [COUNT_BITS-1:0] s1_new;
    logic                  s1_wr;

    assign s1_old = (r_wb_vld && (r_wb_addr == r_s1_addr)) ? r_wb_data : rd_data;
    assign s1_new = (s1_old == COUNT_MAX) ? s1_old : s1_old + 1'b1;
    // a clear taken in the same cycle wins over the pending increment
    assign s1_wr  = r_s1_vld && !clr_acc;

    // scan pointer, emitted counter and output register
    logic [PTR_W-1:0]  r_scan, n_scan;
    logic [POS_W-1:0]  r_emitted, n_emitted;
    logic              r_out_vld, n_out_vld;
    logic              r_out_found, n_out_found;
    logic [BYTE_W-1:0] r_out_sym, n_out_sym;
    logic [OCC_W-1:0]  r_out_occ, n_out_occ;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic              out_free;
    logic              scan_done;

    assign out_free  = !r_out_vld || m_axis_tready;
    assign scan_done = (r_scan == SCAN_END);

    // memory port use
    t_store_req store_req;

    always_comb begin
        store_req         = '0;
        store_req.wr_en   = s1_wr;
        store_req.wr_addr = r_s1_addr;
        store_req.wr_data = s1_new;
        store_req.clr     = clr_acc;
        if (cnt_acc) begin
            store_req.rd_en   = byte_in_range;
            store_req.rd_addr = byte_value[ADDR_W-1:0];
        end else if (r_state == ST_ISSUE) begin
            store_req.rd_en   = !scan_done;
            store_req.rd_addr = r_scan[ADDR_W-1:0];
        end
    end

    bhc_bin_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    // read-out walk
    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_emitted   = r_emitted;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out_found = r_out_found;
        n_out_sym   = r_out_sym;
        n_out_occ   = r_out_occ;
        n_out_pos   = r_out_pos;
        unique case (r_state)
            ST_IDLE: begin
                if (rd_acc) begin
                    n_state = ST_ISSUE;
                end else if (clr_acc) begin
                    n_scan    = '0;
                    n_emitted = '0;
                end
            end
            ST_ISSUE: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (scan_done) begin
                    // read-out exhausted
                    if (out_free) begin
                        n_out_vld   = 1'b1;
                        n_out_found = 1'b0;
                        n_out_sym   = '0;
                        n_out_occ   = '0;
                        n_out_pos   = r_emitted;
                        n_state     = ST_IDLE;
                    end
                end else if (rd_data != '0) begin
                    // present symbol, wait here until the output is free
                    if (out_free) begin
                        n_out_vld   = 1'b1;
                        n_out_found = 1'b1;
                        n_out_sym   = BYTE_W'(r_scan);
                        n_out_occ   = OCC_W'(rd_data);
                        n_out_pos   = r_emitted;
                        n_scan      = r_scan + 1'b1;
                        n_emitted   = r_emitted + 1'b1;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    // empty bin, go on to the next one
                    n_scan  = r_scan + 1'b1;
                    n_state = ST_ISSUE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_scan    <= '0;
            r_emitted <= '0;
            r_out_vld <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_wb_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scan    <= n_scan;
            r_emitted <= n_emitted;
            r_out_vld <= n_out_vld;
            r_s1_vld  <= cnt_acc && byte_in_range;
            r_wb_vld  <= s1_wr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_found <= n_out_found;
        r_out_sym   <= n_out_sym;
        r_out_occ   <= n_out_occ;
        r_out_pos   <= n_out_pos;
        r_s1_addr   <= byte_value[ADDR_W-1:0];
        r_wb_addr   <= r_s1_addr;
        r_wb_data   <= s1_new;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out_pos, r_out_occ, r_out_sym, r_out_found};

    `BHC_ASSERT_IMPL(a_accept_only_idle, s_axis_tvalid && s_axis_tready, r_state == ST_IDLE)
    `BHC_ASSERT_ALWAYS(a_scan_in_range, r_scan <= SCAN_END)
    `BHC_ASSERT_ALWAYS(a_emitted_behind_scan, {1'b0, r_emitted} <= {1'b0, r_scan})
    `BHC_ASSERT_NEXT(a_clear_resets_scan, clr_acc, (r_scan == '0) && (r_emitted == '0))
    `BHC_ASSERT_IMPL(a_exhausted_empty, r_out_vld && !r_out_found, (r_out_occ == '0) && (r_out_sym == '0))

endmodule

FILE: verif/byte_histogram_compactor_tb.sv
// testbench for byte_histogram_compactor: directed and random count, read, clear requests
// predicts every read-out from its own copy of the bins, checks fields in order
// depends on bhc_pkg and the byte_histogram_compactor rtl
module byte_histogram_compactor_tb;
    import bhc_pkg::*;

    // command code the block has no use for
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int ITEMS_TARGET  = 2000;
    localparam int QUIET_LIMIT   = 5000;   // cycles without any request moving
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 30;

    // result bit positions in m_axis_tdata
    localparam int FOUND_LSB = 0;
    localparam int SYM_LSB   = 1;
    localparam int OCC_LSB   = SYM_LSB + BYTE_W;
    localparam int POS_LSB   = OCC_LSB + OCC_W;
    localparam int PAD_LSB   = POS_LSB + POS_W;
    localparam int PAD_W     = 56 - PAD_LSB;

    typedef struct packed {
        logic              found;
        logic [BYTE_W-1:0] symbol;
        logic [OCC_W-1:0]  occurrences;
        logic [POS_W-1:0]  list_position;
    } t_readout;

    // dut inputs, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] byte_value
    logic [1:0]  s_axis_tuser = '0;     // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // [0] found, [8:1] symbol, [40:9] occurrences,
                                        // [49:41] list_position, [55:50] zero

    // predicted histogram state
    logic [COUNT_BITS-1:0] bin_tally [SYMBOLS];
    logic [PTR_W-1:0]      scan_ptr = '0;
    logic [POS_W-1:0]      emitted = '0;
    logic                  last_read_found = 1'b0;
    t_readout              pending_readouts [$];

    // run bookkeeping
    int mismatch_count = 0;
    int items_sent = 0;
    bit src_idling = 1'b0;
    bit sink_idling = 1'b0;
    bit sink_hold_request = 1'b0;

    byte_histogram_compactor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    initial begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
    end

    // gap length: none when not enabled, else mostly none or short, now and then long
    function automatic int pick_gap(input bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // update the predicted bins for one accepted request, queue any read-out
    task automatic histogram_apply(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value);
        t_readout r;
        r = '0;
        case (cmd)
            CMD_COUNT: begin
                // saturating count, bytes outside the symbol set are dropped
                if (int'(value) < SYMBOLS && bin_tally[value] != COUNT_MAX)
                    bin_tally[value] = bin_tally[value] + 1'b1;
            end
            CMD_CLEAR: begin
                foreach (bin_tally[i]) bin_tally[i] = '0;
                scan_ptr = '0;
                emitted  = '0;
            end
            CMD_READ: begin
                // walk forward to the next present bin; bins behind the pointer stay passed
                while (scan_ptr < SCAN_END && bin_tally[scan_ptr] == '0)
                    scan_ptr++;
                if (scan_ptr < SCAN_END) begin
                    r.found         = 1'b1;
                    r.symbol        = BYTE_W'(scan_ptr);
                    r.occurrences   = OCC_W'(bin_tally[scan_ptr]);
                    r.list_position = emitted;
                    scan_ptr++;
                    emitted++;
                end else begin
                    // exhausted: pointer rests at the end, position is the total so far
                    r.list_position = emitted;
                end
                last_read_found = r.found;
                pending_readouts.push_back(r);
            end
            default: ;  // unused code, no effect
        endcase
    endtask

    // offer one request, hold it until taken, then predict its effect
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value);
        int gap;
        gap = pick_gap(src_idling);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        histogram_apply(cmd, value);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic check_field(input string field_name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h actual %0h",
                         $time, field_name, exp_v, act_v);
        end
    endtask

    // receiver: random stalls, plus a long hold-off when a test asks for one
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_request) begin
                sink_hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(sink_idling);
            end
        end
    end

    // result checker: each accepted read-out against the oldest prediction
    initial begin
        t_readout exp_r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_readouts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: read-out with nothing expected: expected none actual %0h",
                                 $time, m_axis_tdata);
                end else begin
                    exp_r = pending_readouts.pop_front();
                    check_field("found", exp_r.found, m_axis_tdata[FOUND_LSB]);
                    check_field("symbol", exp_r.symbol, m_axis_tdata[SYM_LSB +: BYTE_W]);
                    check_field("occurrences", exp_r.occurrences,
                                m_axis_tdata[OCC_LSB +: OCC_W]);
                    check_field("list_position", exp_r.list_position,
                                m_axis_tdata[POS_LSB +: POS_W]);
                    check_field("padding", '0, m_axis_tdata[PAD_LSB +: PAD_W]);
                end
            end
        end
    end

    // watchdog: too long without any request moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // hand-picked sequence: empty read, pointer resting at the end, all commands,
    // counting behind and ahead of the scan pointer, repeat of the same byte
    // back to back; saturation needs 2^32 counts and is out of reach here
    task automatic test_directed_readout();
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        send_request(CMD_READ, 8'h00);      // empty histogram
        send_request(CMD_COUNT, 8'h00);
        send_request(CMD_READ, 8'hFF);      // pointer already at the end
        send_request(CMD_CLEAR, 8'h00);
        send_request(CMD_COUNT, 8'hFF);
        send_request(CMD_COUNT, 8'hFF);     // same byte twice in a row
        send_request(CMD_COUNT, 8'h00);
        send_request(CMD_COUNT, 8'h55);
        send_request(CMD_COUNT, 8'hAA);
        send_request(CMD_UNUSED, 8'hAA);    // must not count
        send_request(CMD_COUNT, 8'h80);
        send_request(CMD_READ, 8'h00);
        send_request(CMD_COUNT, 8'h00);     // bin already passed
        send_request(CMD_READ, 8'h00);
        send_request(CMD_COUNT, 8'h01);     // passed as well
        send_request(CMD_READ, 8'h00);
        send_request(CMD_COUNT, 8'hAA);     // still ahead, counts
        send_request(CMD_READ, 8'h00);
        send_request(CMD_READ, 8'h00);
        send_request(CMD_READ, 8'h00);      // exhausted
        send_request(CMD_READ, 8'h00);      // stays exhausted
        send_request(CMD_UNUSED, 8'h55);
        send_request(CMD_CLEAR, 8'hFF);
        send_request(CMD_READ, 8'h00);
    endtask

    // every symbol present: list positions run up to the full table
    task automatic test_full_table();
        int i;
        src_idling  = 1'b1;
        sink_idling = 1'b1;
        send_request(CMD_CLEAR, 8'h00);
        for (i = 0; i < SYMBOLS; i++)
            send_request(CMD_COUNT, BYTE_W'(i * 37 + 11));
        last_read_found = 1'b1;
        while (last_read_found)
            send_request(CMD_READ, BYTE_W'($urandom));
        send_request(CMD_CLEAR, 8'h00);
    endtask

    // receiver holds off for long while reads keep coming, input must stall
    task automatic test_output_hold();
        int i;
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        send_request(CMD_CLEAR, 8'h00);
        for (i = 0; i < 24; i++)
            send_request(CMD_COUNT, BYTE_W'(i * 11));
        sink_hold_request = 1'b1;
        for (i = 0; i < 12; i++) begin
            send_request(CMD_READ, 8'h00);
            send_request(CMD_COUNT, BYTE_W'($urandom));
        end
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(input int mode, input logic [BYTE_W-1:0] a0,
                                                    input logic [BYTE_W-1:0] a1,
                                                    input logic [BYTE_W-1:0] a2);
        case (mode)
            0: return BYTE_W'($urandom);
            1: begin
                case ($urandom_range(0, 2))
                    0: return a0;
                    1: return a1;
                    default: return a2;
                endcase
            end
            default: begin
                // ends of the byte range and the sign boundary
                case ($urandom_range(0, 5))
                    0: return 8'h00;
                    1: return 8'h01;
                    2: return 8'h7F;
                    3: return 8'h80;
                    4: return 8'hFE;
                    default: return 8'hFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return CMD_COUNT;
        if (roll < 8)
            return CMD_READ;
        if (roll < 9)
            return CMD_CLEAR;
        return CMD_UNUSED;
    endfunction

    // mostly clean sessions (clear, counts, read-out to the end), some noise
    task automatic test_random_sessions(input int target);
        int kind;
        int n;
        int mode;
        logic [BYTE_W-1:0] a0, a1, a2;
        while (items_sent < target) begin
            src_idling  = ($urandom_range(0, 3) != 0);
            sink_idling = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                mode = $urandom_range(0, 2);
                a0 = BYTE_W'($urandom);
                a1 = BYTE_W'($urandom);
                a2 = BYTE_W'($urandom);
                send_request(CMD_CLEAR, BYTE_W'($urandom));
                n = $urandom_range(1, 60);
                repeat (n) send_request(CMD_COUNT, pick_byte(mode, a0, a1, a2));
                last_read_found = 1'b1;
                while (last_read_found) begin
                    // occasional count while reading out
                    if ($urandom_range(0, 7) == 0)
                        send_request(CMD_COUNT, pick_byte(mode, a0, a1, a2));
                    send_request(CMD_READ, BYTE_W'($urandom));
                end
                if ($urandom_range(0, 1) == 0)
                    send_request(CMD_READ, BYTE_W'($urandom));
            end else begin
                n = $urandom_range(5, 40);
                repeat (n) send_request(pick_cmd(), BYTE_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_readout();
        test_full_table();
        test_output_hold();
        test_random_sessions(ITEMS_TARGET);

        // stop offering, let every read-out come home, then watch for strays
        s_axis_tvalid <= 1'b0;
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/bhc_pkg.sv
rtl/bhc_bin_store.sv
rtl/byte_histogram_compactor.sv
verif/byte_histogram_compactor_tb.sv
